@@ src/bpt_pkg.sv @@
// bpt_pkg: widths, constants and the sigmoid table builder for the batch trainer
// no dependencies; used by every other file of the block but bpt_if
package bpt_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int NREG      = 8;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // shared multiplier: A operand, B operand, product
  localparam int AW = 40;
  localparam int BW = 18;
  localparam int PW = AW + BW;

  // register widths
  localparam int WW     = 32;
  localparam int GW     = 48;
  localparam int CW     = 25;
  localparam int NET_W  = PW + 1 - FRAC_BITS;
  localparam int SIG_W  = 16;
  localparam int SERR_W = 17;

  // learning rate 0.1 in Q.F
  localparam logic signed [BW-1:0] LEARN_Q = BW'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [BW-1:0]        ONE_Q   = BW'(1 << FRAC_BITS);

  // register reset values, in register order
  localparam logic [DATA_W-1:0] CFG_RESET [NREG] = '{
    32'd9830, 32'd13107, 32'd16384, 32'd19661,
    32'd22938, 32'd26214, 32'd29491, 32'd32768
  };

  localparam logic [63:0] Q28 = 64'd1 << 28;

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    int          i;
    q = '0;
    r = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-f in Q28 for f in [0,1] in Q28, alternating series
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int                 i;
    sum  = '0;
    term = Q28;
    for (i = 0; i < 24; i++) begin
      if (i[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
      term = udiv64((term * f) >> 28, 64'(i + 1));
    end
    return (sum < 0) ? 64'd0 : $unsigned(sum);
  endfunction

  // sigmoid at the center of bucket k, Q0.F, capped below one
  function automatic logic [SIG_W-1:0] sig_entry(input int k, input int depth);
    logic [63:0]        einv;
    logic [63:0]        a;
    logic [63:0]        n;
    logic [63:0]        d;
    logic [63:0]        den;
    logic [63:0]        num;
    logic [63:0]        s;
    logic signed [63:0] xq;
    int                 i;
    einv = exp_neg_frac(Q28);
    xq   = $signed(udiv64(64'(2 * k + 1) << 31, 64'(depth))) - (64'sd1 <<< 31);
    a    = (xq < 0) ? $unsigned(-xq) : $unsigned(xq);
    n    = a >> 28;
    d    = exp_neg_frac(a & (Q28 - 64'd1));
    for (i = 0; i < 16; i++) begin
      if (64'(i) < n) d = (d * einv) >> 28;
    end
    den = Q28 + d;
    num = (xq >= 0) ? (64'd1 << (FRAC_BITS + 28)) : (d << FRAC_BITS);
    s   = udiv64(num + (den >> 1), den);
    if (s > (64'd1 << FRAC_BITS) - 64'd1) s = (64'd1 << FRAC_BITS) - 64'd1;
    return s[SIG_W-1:0];
  endfunction

endpackage

@@ src/bpt_if.sv @@
// bpt_in_if / bpt_out_if: valid/ready channels for training requests and results
// no dependencies
interface bpt_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] feature0;
  logic [15:0] feature1;
  logic [15:0] target0;
  logic [15:0] target1;
  logic        batch_end;

  modport source (output valid, func, feature0, feature1, target0, target1, batch_end,
                  input ready);
  modport sink   (input valid, func, feature0, feature1, target0, target1, batch_end,
                  output ready);
endinterface

interface bpt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] prediction0;
  logic [15:0] prediction1;
  logic [16:0] sample_error;
  logic [24:0] batch_cost;
  logic        weights_updated;

  modport source (output valid, prediction0, prediction1, sample_error, batch_cost,
                  weights_updated, input ready);
  modport sink   (input valid, prediction0, prediction1, sample_error, batch_cost,
                  weights_updated, output ready);
endinterface

@@ src/mlp_batch_backprop_trainer.sv @@
// mlp_batch_backprop_trainer: top level, sequencer, weights and accumulators
// depends on bpt_pkg, bpt_if, bpt_cfg, bpt_mul, bpt_sigmoid
//
// Trains a 2-2-2 sigmoid network by full-batch gradient descent.
// req_i carries one request per item: func 0 trains on the sample, func 1 reloads
// the weights from the APB registers and clears the gradient and cost sums.
// rsp_o returns one result per request: both predictions, the sample's squared
// error, the running batch cost and a flag for a weight update.
// A training request runs 31 sequencer steps through one shared 40x18 multiplier
// and the registered sigmoid table, then its result goes to the output register.
// With batch_end set, the update follows, taking each weight through the
// PH_Q, PH_R and PH_W phases. A reload goes straight to the done state.
// req_i.ready is high only while the sequencer is idle; one request is in work
// at a time.
// The result sits in an output register; if rsp_o is stalled, the next request
// is still taken and worked on, and its result waits until the register drains.
// APB writes change only the initial weights, which take effect on a reload.
// Reset loads the weights from the register reset values and clears the sums.
module mlp_batch_backprop_trainer #(
  parameter int SIGMOID_TABLE_DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bpt_in_if.sink                     req_i,
  bpt_out_if.source                  rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpt_pkg::ADDR_W-1:0] paddr,
  input  logic [bpt_pkg::DATA_W-1:0] pwdata,
  output logic [bpt_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bpt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [1:0] PH_Q = 2'd0;
  localparam logic [1:0] PH_R = 2'd1;
  localparam logic [1:0] PH_W = 2'd2;

  logic [DATA_W-1:0] cfg [NREG];

  // sequencer
  logic [1:0] state_q, state_d;
  logic [4:0] step_q, step_d;
  logic [2:0] upd_k_q, upd_k_d;
  logic [1:0] ph_q, ph_d;

  // item and intermediates
  logic [15:0]               x0_q, x0_d, x1_q, x1_d, t0_q, t0_d, t1_q, t1_d;
  logic                      be_q, be_d;
  logic [SIG_W-1:0]          h0_q, h0_d, h1_q, h1_d, o0_q, o0_d, o1_q, o1_d;
  logic [SERR_W-1:0]         serr_q, serr_d;
  logic signed [AW-1:0]      tmp_q, tmp_d, tmp2_q, tmp2_d, dh0_q, dh0_d, dh1_q, dh1_d;
  logic signed [BW-1:0]      d0_q, d0_d, d1_q, d1_d;
  logic signed [PW-1:0]      acc_q, acc_d, acc2_q, acc2_d;
  logic [CW-1:0]             rep_q, rep_d;
  logic                      upd_q, upd_d;

  // architectural state
  logic signed [WW-1:0]      w_q [NREG];
  logic signed [WW-1:0]      w_d [NREG];
  logic signed [GW-1:0]      g_q [NREG];
  logic signed [GW-1:0]      g_d [NREG];
  logic [CW-1:0]             cost_q, cost_d;

  // output register
  logic                      rv_q, rv_d;
  logic [SIG_W-1:0]          rp0_q, rp0_d, rp1_q, rp1_d;
  logic [SERR_W-1:0]         rse_q, rse_d;
  logic [CW-1:0]             rc_q, rc_d;
  logic                      ru_q, ru_d;

  // datapath
  logic signed [AW-1:0]      op_a;
  logic signed [BW-1:0]      op_b;
  logic signed [PW-1:0]      prod;
  logic signed [PW:0]        sum_w, sum2_w;
  logic [SIG_W-1:0]          sig;
  logic signed [SERR_W-1:0]  e0, e1;
  logic [BW-1:0]             om0, om1, hm0, hm1;
  logic signed [AW-1:0]      psh;

  // gradient adder
  logic                      g_wen;
  logic [2:0]                g_idx, g_rd;
  logic signed [GW-1:0]      g_sel;
  logic signed [GW:0]        g_sum;
  logic signed [GW-1:0]      g_sat;
  logic signed [WW-1:0]      w_sel;
  logic signed [PW-1:0]      stp, nw;
  logic signed [WW-1:0]      nw_sat;
  logic [CW:0]               csum;

  bpt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpt_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  // net of two accumulated products, shifted back to Q.F
  assign sum_w  = {acc_q[PW-1], acc_q} + {prod[PW-1], prod};
  assign sum2_w = {acc2_q[PW-1], acc2_q} + {prod[PW-1], prod};

  // table value is registered, so it shows up in the cycle after its net
  bpt_sigmoid #(.DEPTH(SIGMOID_TABLE_DEPTH)) u_sig (
    .clk_i (clk_i),
    .net_i (sum_w[PW:FRAC_BITS]),
    .sig_o (sig)
  );

  // errors and one-minus terms
  assign e0  = $signed({1'b0, o0_q}) - $signed({1'b0, t0_q});
  assign e1  = $signed({1'b0, o1_q}) - $signed({1'b0, t1_q});
  assign om0 = ONE_Q - {2'b00, o0_q};
  assign om1 = ONE_Q - {2'b00, o1_q};
  assign hm0 = ONE_Q - {2'b00, h0_q};
  assign hm1 = ONE_Q - {2'b00, h1_q};
  assign psh = prod[FRAC_BITS+AW-1:FRAC_BITS];

  // gradient slot per step
  always_comb begin
    g_wen = (state_q == ST_RUN) && (step_q >= 5'd23);
    unique case (step_q)
      5'd23:   g_idx = 3'd4;
      5'd24:   g_idx = 3'd5;
      5'd25:   g_idx = 3'd6;
      5'd26:   g_idx = 3'd7;
      5'd27:   g_idx = 3'd0;
      5'd28:   g_idx = 3'd1;
      5'd29:   g_idx = 3'd2;
      5'd30:   g_idx = 3'd3;
      default: g_idx = 3'd0;
    endcase
  end

  assign g_rd  = (state_q == ST_UPD) ? upd_k_q : g_idx;
  assign g_sel = g_q[g_rd];
  assign w_sel = w_q[upd_k_q];

  // saturating gradient accumulate
  always_comb begin
    g_sum = {g_sel[GW-1], g_sel}
          + {{(GW + 1 - (PW - FRAC_BITS)){prod[PW-1]}}, prod[PW-1:FRAC_BITS]};
    if (g_sum[GW] != g_sum[GW-1]) begin
      g_sat = g_sum[GW] ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
    end else begin
      g_sat = g_sum[GW-1:0];
    end
  end

  // weight update step and saturation
  always_comb begin
    stp = acc_q + {{FRAC_BITS{prod[PW-1]}}, prod[PW-1:FRAC_BITS]};
    nw  = {{(PW-WW){w_sel[WW-1]}}, w_sel} - stp;
    if (nw[PW-1:WW-1] != {(PW-WW+1){nw[PW-1]}}) begin
      nw_sat = nw[PW-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end else begin
      nw_sat = nw[WW-1:0];
    end
  end

  assign csum = {1'b0, cost_q} + (CW+1)'(serr_q);

  assign req_i.ready = (state_q == ST_IDLE);

  // sequencer and operand selection
  always_comb begin
    state_d = state_q;  step_d = step_q;  upd_k_d = upd_k_q;  ph_d = ph_q;
    x0_d = x0_q;  x1_d = x1_q;  t0_d = t0_q;  t1_d = t1_q;  be_d = be_q;
    h0_d = h0_q;  h1_d = h1_q;  o0_d = o0_q;  o1_d = o1_q;  serr_d = serr_q;
    tmp_d = tmp_q;  tmp2_d = tmp2_q;  dh0_d = dh0_q;  dh1_d = dh1_q;
    d0_d = d0_q;  d1_d = d1_q;  acc_d = acc_q;  acc2_d = acc2_q;
    rep_d = rep_q;  upd_d = upd_q;
    w_d = w_q;  g_d = g_q;  cost_d = cost_q;
    rp0_d = rp0_q;  rp1_d = rp1_q;  rse_d = rse_q;  rc_d = rc_q;  ru_d = ru_q;
    rv_d  = rv_q && !rsp_o.ready;
    op_a  = '0;
    op_b  = '0;

    if (g_wen) g_d[g_idx] = g_sat;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          x0_d = req_i.feature0;  x1_d = req_i.feature1;
          t0_d = req_i.target0;   t1_d = req_i.target1;
          be_d = req_i.batch_end;
          upd_d = 1'b0;
          if (req_i.func) begin
            // reload: fresh weights, cleared sums, zero result
            for (int i = 0; i < NREG; i++) begin
              w_d[i] = $signed(cfg[i]);
              g_d[i] = '0;
            end
            cost_d = '0;
            o0_d = '0;  o1_d = '0;  serr_d = '0;  rep_d = '0;
            state_d = ST_DONE;
          end else begin
            step_d  = '0;
            state_d = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        step_d = step_q + 5'd1;
        unique case (step_q)
          5'd0:  begin op_a = AW'(w_q[0]); op_b = {2'b00, x0_q}; end
          5'd1:  begin acc_d = prod; op_a = AW'(w_q[1]); op_b = {2'b00, x1_q}; end
          5'd2:  begin op_a = AW'(w_q[2]); op_b = {2'b00, x0_q}; end
          5'd3:  begin
            h0_d = sig; acc_d = prod;
            op_a = AW'(w_q[3]); op_b = {2'b00, x1_q};
          end
          5'd4:  begin op_a = AW'(w_q[4]); op_b = {2'b00, h0_q}; end
          5'd5:  begin
            h1_d = sig; acc_d = prod;
            op_a = AW'(w_q[5]); op_b = {2'b00, sig};
          end
          5'd6:  begin op_a = AW'(w_q[6]); op_b = {2'b00, h0_q}; end
          5'd7:  begin
            o0_d = sig; acc_d = prod;
            op_a = AW'(w_q[7]); op_b = {2'b00, h1_q};
          end
          5'd8:  begin op_a = AW'(e0); op_b = BW'(e0); end
          5'd9:  begin
            o1_d   = sig;
            serr_d = prod[FRAC_BITS+SERR_W-1:FRAC_BITS];
            op_a = AW'(e0); op_b = {2'b00, o0_q};
          end
          5'd10: begin tmp_d = psh; op_a = AW'(e1); op_b = BW'(e1); end
          5'd11: begin
            serr_d = serr_q + prod[FRAC_BITS+SERR_W-1:FRAC_BITS];
            op_a = tmp_q; op_b = om0;
          end
          5'd12: begin
            d0_d = prod[FRAC_BITS+BW-1:FRAC_BITS];
            op_a = AW'(e1); op_b = {2'b00, o1_q};
          end
          5'd13: begin tmp_d = psh; op_a = AW'(w_q[4]); op_b = d0_q; end
          5'd14: begin acc_d = prod; op_a = tmp_q; op_b = om1; end
          5'd15: begin
            d1_d = prod[FRAC_BITS+BW-1:FRAC_BITS];
            op_a = AW'(w_q[5]); op_b = d0_q;
          end
          5'd16: begin acc2_d = prod; op_a = AW'(w_q[6]); op_b = d1_q; end
          5'd17: begin
            tmp_d = sum_w[FRAC_BITS+AW-1:FRAC_BITS];
            op_a = AW'(w_q[7]); op_b = d1_q;
          end
          5'd18: begin
            tmp2_d = sum2_w[FRAC_BITS+AW-1:FRAC_BITS];
            op_a = tmp_q; op_b = {2'b00, h0_q};
          end
          5'd19: begin tmp_d = psh; op_a = tmp2_q; op_b = {2'b00, h1_q}; end
          5'd20: begin tmp2_d = psh; op_a = tmp_q; op_b = hm0; end
          5'd21: begin dh0_d = psh; op_a = tmp2_q; op_b = hm1; end
          5'd22: begin dh1_d = psh; op_a = AW'(d0_q); op_b = {2'b00, h0_q}; end
          5'd23: begin op_a = AW'(d0_q); op_b = {2'b00, h1_q}; end
          5'd24: begin op_a = AW'(d1_q); op_b = {2'b00, h0_q}; end
          5'd25: begin op_a = AW'(d1_q); op_b = {2'b00, h1_q}; end
          5'd26: begin op_a = dh0_q; op_b = {2'b00, x0_q}; end
          5'd27: begin op_a = dh0_q; op_b = {2'b00, x1_q}; end
          5'd28: begin op_a = dh1_q; op_b = {2'b00, x0_q}; end
          5'd29: begin op_a = dh1_q; op_b = {2'b00, x1_q}; end
          5'd30: begin
            // saturating batch cost, reported with this item
            cost_d = csum[CW] ? {CW{1'b1}} : csum[CW-1:0];
            rep_d  = csum[CW] ? {CW{1'b1}} : csum[CW-1:0];
            if (be_q) begin
              upd_k_d = '0;
              ph_d    = PH_Q;
              state_d = ST_UPD;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_UPD: begin
        unique case (ph_q)
          PH_Q: begin
            op_a = AW'($signed(g_sel[GW-1:FRAC_BITS]));
            op_b = LEARN_Q;
            ph_d = PH_R;
          end
          PH_R: begin
            acc_d = prod;
            op_a  = AW'({1'b0, g_sel[FRAC_BITS-1:0]});
            op_b  = LEARN_Q;
            ph_d  = PH_W;
          end
          PH_W: begin
            w_d[upd_k_q] = nw_sat;
            upd_k_d      = upd_k_q + 3'd1;
            ph_d         = PH_Q;
            if (upd_k_q == 3'(NREG - 1)) begin
              for (int i = 0; i < NREG; i++) g_d[i] = '0;
              cost_d  = '0;
              upd_d   = 1'b1;
              state_d = ST_DONE;
            end
          end
          default: ph_d = PH_Q;
        endcase
      end

      ST_DONE: begin
        if (!rv_q || rsp_o.ready) begin
          rv_d  = 1'b1;
          rp0_d = o0_q;
          rp1_d = o1_q;
          rse_d = serr_q;
          rc_d  = rep_q;
          ru_d  = upd_q;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      upd_k_q <= '0;
      ph_q    <= PH_Q;
      rv_q    <= 1'b0;
      cost_q  <= '0;
      for (int i = 0; i < NREG; i++) begin
        w_q[i] <= $signed(CFG_RESET[i]);
        g_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      upd_k_q <= upd_k_d;
      ph_q    <= ph_d;
      rv_q    <= rv_d;
      cost_q  <= cost_d;
      w_q     <= w_d;
      g_q     <= g_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x0_q <= x0_d;  x1_q <= x1_d;  t0_q <= t0_d;  t1_q <= t1_d;  be_q <= be_d;
    h0_q <= h0_d;  h1_q <= h1_d;  o0_q <= o0_d;  o1_q <= o1_d;  serr_q <= serr_d;
    tmp_q <= tmp_d;  tmp2_q <= tmp2_d;  dh0_q <= dh0_d;  dh1_q <= dh1_d;
    d0_q <= d0_d;  d1_q <= d1_d;  acc_q <= acc_d;  acc2_q <= acc2_d;
    rep_q <= rep_d;  upd_q <= upd_d;
    rp0_q <= rp0_d;  rp1_q <= rp1_d;  rse_q <= rse_d;  rc_q <= rc_d;  ru_q <= ru_d;
  end

  assign rsp_o.valid           = rv_q;
  assign rsp_o.prediction0     = rp0_q;
  assign rsp_o.prediction1     = rp1_q;
  assign rsp_o.sample_error    = rse_q;
  assign rsp_o.batch_cost      = rc_q;
  assign rsp_o.weights_updated = ru_q;

  // a training request starts the sequence at its first step
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && !req_i.func) |=> (state_q == ST_RUN && step_q == '0))
    else $error("training request did not start the sequencer");

  // a new result only comes out of the done state
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the done state");

  // the update index sweeps fully and is back at zero outside the update
  a_upd_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_UPD) |-> (upd_k_q == '0))
    else $error("update index left mid sweep");

  // updates only run for an item that closes a batch
  a_upd_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> be_q)
    else $error("weight update without batch end");

endmodule

@@ src/bpt_cfg.sv @@
// bpt_cfg: APB register file holding the eight initial weights
// depends on bpt_pkg
module bpt_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpt_pkg::ADDR_W-1:0] paddr,
  input  logic [bpt_pkg::DATA_W-1:0] pwdata,
  output logic [bpt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [bpt_pkg::DATA_W-1:0] cfg_o [bpt_pkg::NREG]
);
  import bpt_pkg::*;

  logic [DATA_W-1:0] reg_q [NREG];
  logic [2:0]        idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign prdata = reg_q[idx];
  assign cfg_o  = reg_q;

  // register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      reg_q[idx] <= pwdata;
    end
  end

endmodule

@@ src/bpt_mul.sv @@
// bpt_mul: shared signed multiplier with registered product
// depends on bpt_pkg
module bpt_mul (
  input  logic                          clk_i,
  input  logic signed [bpt_pkg::AW-1:0] a_i,
  input  logic signed [bpt_pkg::BW-1:0] b_i,
  output logic signed [bpt_pkg::PW-1:0] prod_o
);
  import bpt_pkg::*;

  // one product per cycle
  always_ff @(posedge clk_i) begin
    prod_o <= PW'(a_i * b_i);
  end

endmodule

@@ src/bpt_sigmoid.sv @@
// bpt_sigmoid: sigmoid lookup over net values -8..8 with saturation outside
// depends on bpt_pkg (table builder); DEPTH must be a power of two; registered read
module bpt_sigmoid #(
  parameter int DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic signed [bpt_pkg::NET_W-1:0] net_i,
  output logic        [bpt_pkg::SIG_W-1:0] sig_o
);
  import bpt_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam logic signed [NET_W-1:0] OFF_P = NET_W'(8 << FRAC_BITS);
  localparam logic signed [NET_W-1:0] OFF_N = -OFF_P;

  logic [SIG_W-1:0]        tab [DEPTH];
  logic signed [NET_W:0]   ofs;
  logic [IW-1:0]           addr;

  // constant table built at elaboration
  for (genvar k = 0; k < DEPTH; k++) begin : g_tab
    localparam logic [SIG_W-1:0] V = sig_entry(k, DEPTH);
    assign tab[k] = V;
  end

  assign ofs = {net_i[NET_W-1], net_i} + {OFF_P[NET_W-1], OFF_P};

  // clamp outside the span, bucket index inside
  always_comb begin
    priority if (net_i < OFF_N) begin
      addr = '0;
    end else if (net_i >= OFF_P) begin
      addr = IW'(DEPTH - 1);
    end else begin
      addr = ofs[FRAC_BITS+3 -: IW];
    end
  end

  // registered table read
  always_ff @(posedge clk_i) begin
    sig_o <= tab[addr];
  end

endmodule
